// ===== src/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

  // Field widths of the coefficient and root words, default fraction bits, tolerance
  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_W         = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // Root-count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] coef_quad;
    logic signed [DATA_W-1:0] coef_lin;
    logic signed [DATA_W-1:0] coef_const;
  } coef_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [DATA_W-1:0] root_first;
    logic signed [DATA_W-1:0] root_second;
    logic                     overflow;
  } roots_t;

endpackage

`default_nettype wire

// ===== src/qrs_sqrt_cell.sv =====
// One step of the square root chain: settles one root bit per cell.
// Depends on nothing; instantiated in a row by the top level.
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt_cell #(
  parameter int R  = 33,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          v_in,
  input  wire logic [2*R-1:0] rad_in,
  input  wire logic [R+2:0]  rem_in,
  input  wire logic [R-1:0]  root_in,
  input  wire logic [SW-1:0] side_in,
  output logic               v_out,
  output logic [2*R-1:0]     rad_out,
  output logic [R+2:0]       rem_out,
  output logic [R-1:0]       root_out,
  output logic [SW-1:0]      side_out
);

  localparam int RMW = R + 3;

  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic           ge;

  // bring in the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem_in[RMW-3:0], rad_in[2*R-1:2*R-2]};
    trial  = RMW'({root_in, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[2*R-3:0], 2'b00};
      rem_out  <= ge ? (rem_sh - trial) : rem_sh;
      root_out <= {root_in[R-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/qrs_div_cell.sv =====
// One step of a restoring divider chain: settles one quotient bit per cell.
// Depends on nothing; instantiated in rows by the top level.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div_cell #(
  parameter int NW   = 50,
  parameter int DENW = 33,
  parameter int SW   = 3
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire logic [NW-1:0]   nq_in,
  input  wire logic [DENW-1:0] rem_in,
  input  wire logic [DENW-1:0] den_in,
  input  wire logic [SW-1:0]   side_in,
  output logic                 v_out,
  output logic [NW-1:0]        nq_out,
  output logic [DENW-1:0]      rem_out,
  output logic [DENW-1:0]      den_out,
  output logic [SW-1:0]        side_out
);

  logic [DENW:0] rem_sh;
  logic [DENW:0] rem_sub;
  logic          ge;

  // numerator bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    rem_sh  = {rem_in, nq_in[NW-1]};
    ge      = (rem_sh >= {1'b0, den_in});
    rem_sub = rem_sh - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_out   <= {nq_in[NW-2:0], ge};
      rem_out  <= ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/quadratic_root_solver_top.sv =====
// Quadratic root solver: front stages, square root chain, two divider chains.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
// Path: stage 1 and 2 registers, the 33-cell square root chain and the
// (34 + FRAC_BITS)-cell divider chains, each with an input register, then the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, clears all valid bits and sets tolerance to 1.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver_top #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire qrs_pkg::coef_t           coef,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output qrs_pkg::roots_t               roots,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [qrs_pkg::TOL_W-1:0] cfg_data
);
  import qrs_pkg::*;

  localparam int W    = DATA_W;
  localparam int DW   = 2 * W + 3;
  localparam int DMW  = 2 * W + 2;
  localparam int R    = W + 1;
  localparam int NSW  = W + 3;
  localparam int NMW  = W + 2;
  localparam int NW   = W + 2 + FRAC_BITS;
  localparam int DENW = W + 1;
  localparam int SSW  = 7 + 3 * W;
  localparam int D1W  = 3;

  localparam logic [1:0] MODE_NIL = 2'd0;
  localparam logic [1:0] MODE_LIN = 2'd1;
  localparam logic [1:0] MODE_DBL = 2'd2;
  localparam logic [1:0] MODE_TWO = 2'd3;

  // tolerance register
  logic [TOL_W-1:0] tolerance;
  logic [TOL_W-1:0] thr;
  logic [W-1:0]     thr_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  assign thr   = (tolerance == '0) ? TOL_W'(1) : tolerance;
  assign thr_w = W'(thr);

  // global advance
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: signs and magnitudes
  logic         v1, sa1, sb1, sc1;
  logic [W-1:0] ma1, mb1, mc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1 <= coef.coef_quad[W-1];
      sb1 <= coef.coef_lin[W-1];
      sc1 <= coef.coef_const[W-1];
      ma1 <= coef.coef_quad[W-1]  ? (~coef.coef_quad + 1'b1)  : coef.coef_quad;
      mb1 <= coef.coef_lin[W-1]   ? (~coef.coef_lin + 1'b1)   : coef.coef_lin;
      mc1 <= coef.coef_const[W-1] ? (~coef.coef_const + 1'b1) : coef.coef_const;
    end
  end

  // stage 2: b*b and a*c, near-zero flags
  logic           v2, sa2, sb2, sc2, az2, bz2, cz2;
  logic [W-1:0]   ma2, mb2, mc2;
  logic [2*W-1:0] bb2, ac2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa2 <= sa1;
      sb2 <= sb1;
      sc2 <= sc1;
      ma2 <= ma1;
      mb2 <= mb1;
      mc2 <= mc1;
      az2 <= (ma1 < thr_w);
      bz2 <= (mb1 < thr_w);
      cz2 <= (mc1 < thr_w);
      bb2 <= mb1 * mb1;
      ac2 <= ma1 * mc1;
    end
  end

  // stage 3: discriminant and case selection
  logic [DW-1:0]  d_s, ac4;
  logic           d_neg, d_zero;
  logic [DW-1:0]  d_abs;
  logic [DMW-1:0] thr2;
  logic [1:0]     mode_c, cnt_c;

  always_comb begin
    ac4    = {1'b0, ac2, 2'b00};
    d_s    = (sa2 ^ sc2) ? ({3'b000, bb2} + ac4) : ({3'b000, bb2} - ac4);
    d_neg  = d_s[DW-1];
    d_abs  = d_neg ? (~d_s + 1'b1) : d_s;
    thr2   = DMW'(thr) << FRAC_BITS;
    d_zero = (d_abs[DMW-1:0] < thr2);
    mode_c = MODE_NIL;
    cnt_c  = CNT_NONE;
    if (az2) begin
      if (bz2) begin
        cnt_c = cz2 ? CNT_INF : CNT_NONE;
      end else begin
        mode_c = MODE_LIN;
        cnt_c  = CNT_ONE;
      end
    end else if (d_zero) begin
      mode_c = MODE_DBL;
      cnt_c  = CNT_ONE;
    end else if (!d_neg) begin
      mode_c = MODE_TWO;
      cnt_c  = CNT_TWO;
    end
  end

  // square root chain
  logic [R:0]       sq_v;
  logic [2*R-1:0]   sq_rad  [0:R];
  logic [R+2:0]     sq_rem  [0:R];
  logic [R-1:0]     sq_root [0:R];
  logic [SSW-1:0]   sq_side [0:R];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad[0]  <= d_abs[DMW-1:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_side[0] <= {mode_c, cnt_c, sa2, sb2, sc2, ma2, mb2, mc2};
    end
  end

  for (genvar k = 0; k < R; k++) begin : g_sqrt
    qrs_sqrt_cell #(.R(R), .SW(SSW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (sq_v[k]),
      .rad_in   (sq_rad[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .side_in  (sq_side[k]),
      .v_out    (sq_v[k+1]),
      .rad_out  (sq_rad[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  // stage 4: numerators and divisor
  logic [1:0]     mode4, cnt4;
  logic           sa4, sb4, sc4;
  logic [W-1:0]   ma4, mb4, mc4;
  logic [NSW-1:0] neg_b, neg_c, s_ext, n1, n2;
  logic [NSW-1:0] n1_abs, n2_abs;
  logic           den_neg, neg1_c, neg2_c;
  logic [DENW-1:0] den_c;

  function automatic logic [NSW-1:0] sval(input logic neg, input logic [W-1:0] mag);
    logic [NSW-1:0] e;
    e = NSW'(mag);
    return neg ? (~e + 1'b1) : e;
  endfunction

  always_comb begin
    {mode4, cnt4, sa4, sb4, sc4, ma4, mb4, mc4} = sq_side[R];
    neg_b  = sval(!sb4, mb4);
    neg_c  = sval(!sc4, mc4);
    s_ext  = NSW'(sq_root[R]);
    den_c  = {ma4, 1'b0};
    den_neg = sa4;
    n1     = neg_b;
    n2     = neg_b;
    case (mode4)
      MODE_LIN: begin
        den_c   = {1'b0, mb4};
        den_neg = sb4;
        n1      = neg_c;
        n2      = neg_c;
      end
      MODE_TWO: begin
        n1 = neg_b + s_ext;
        n2 = neg_b - s_ext;
      end
      default: begin
      end
    endcase
    n1_abs = n1[NSW-1] ? (~n1 + 1'b1) : n1;
    n2_abs = n2[NSW-1] ? (~n2 + 1'b1) : n2;
    neg1_c = n1[NSW-1] ^ den_neg;
    neg2_c = n2[NSW-1] ^ den_neg;
  end

  // divider chains, one per root
  logic [NW:0]     dv1_v, dv2_v;
  logic [NW-1:0]   dv1_nq  [0:NW];
  logic [NW-1:0]   dv2_nq  [0:NW];
  logic [DENW-1:0] dv1_rem [0:NW];
  logic [DENW-1:0] dv2_rem [0:NW];
  logic [DENW-1:0] dv1_den [0:NW];
  logic [DENW-1:0] dv2_den [0:NW];
  logic [D1W-1:0]  dv1_side [0:NW];
  logic [0:0]      dv2_side [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv1_v[0] <= 1'b0;
      dv2_v[0] <= 1'b0;
    end else if (en) begin
      dv1_v[0] <= sq_v[R];
      dv2_v[0] <= sq_v[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv1_nq[0]   <= NW'(n1_abs[NMW-1:0]) << FRAC_BITS;
      dv2_nq[0]   <= NW'(n2_abs[NMW-1:0]) << FRAC_BITS;
      dv1_rem[0]  <= '0;
      dv2_rem[0]  <= '0;
      dv1_den[0]  <= den_c;
      dv2_den[0]  <= den_c;
      dv1_side[0] <= {cnt4, neg1_c};
      dv2_side[0] <= neg2_c;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    qrs_div_cell #(.NW(NW), .DENW(DENW), .SW(D1W)) u_first (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (dv1_v[k]),
      .nq_in    (dv1_nq[k]),
      .rem_in   (dv1_rem[k]),
      .den_in   (dv1_den[k]),
      .side_in  (dv1_side[k]),
      .v_out    (dv1_v[k+1]),
      .nq_out   (dv1_nq[k+1]),
      .rem_out  (dv1_rem[k+1]),
      .den_out  (dv1_den[k+1]),
      .side_out (dv1_side[k+1])
    );
    qrs_div_cell #(.NW(NW), .DENW(DENW), .SW(1)) u_second (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (dv2_v[k]),
      .nq_in    (dv2_nq[k]),
      .rem_in   (dv2_rem[k]),
      .den_in   (dv2_den[k]),
      .side_in  (dv2_side[k]),
      .v_out    (dv2_v[k+1]),
      .nq_out   (dv2_nq[k+1]),
      .rem_out  (dv2_rem[k+1]),
      .den_out  (dv2_den[k+1]),
      .side_out (dv2_side[k+1])
    );
  end

  // snap to zero, saturate, encode
  function automatic logic [W:0] finish(input logic [NW-1:0] q, input logic neg,
                                        input logic [W-1:0] tw);
    logic [NW-1:0] lim;
    logic [NW-1:0] qc;
    logic          sat;
    logic [W-1:0]  v;
    lim = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - 1'b1);
    sat = 1'b0;
    qc  = q;
    if (q < NW'(tw)) begin
      qc = '0;
    end else if (q > lim) begin
      qc  = lim;
      sat = 1'b1;
    end
    v = neg ? (~qc[W-1:0] + 1'b1) : qc[W-1:0];
    return {sat, v};
  endfunction

  logic [1:0] cnt_o;
  logic       neg1_o;
  logic [W:0] f1, f2;
  roots_t     roots_next;

  always_comb begin
    {cnt_o, neg1_o} = dv1_side[NW];
    f1 = finish(dv1_nq[NW], neg1_o, thr_w);
    f2 = finish(dv2_nq[NW], dv2_side[NW][0], thr_w);
    roots_next.root_count  = cnt_o;
    roots_next.root_first  = '0;
    roots_next.root_second = '0;
    roots_next.overflow    = 1'b0;
    case (cnt_o)
      CNT_ONE: begin
        roots_next.root_first  = f1[W-1:0];
        roots_next.root_second = f1[W-1:0];
        roots_next.overflow    = f1[W];
      end
      CNT_TWO: begin
        roots_next.root_first  = f1[W-1:0];
        roots_next.root_second = f2[W-1:0];
        roots_next.overflow    = f1[W] | f2[W];
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv1_v[NW] & dv2_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots <= roots_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/qrs_checker.sv =====
// Port-level checks for the quadratic root solver, bound to its top level.
// Depends on qrs_pkg and quadratic_root_solver_top.
`timescale 1ns / 1ps
`default_nettype none

module qrs_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire qrs_pkg::roots_t roots
);
  import qrs_pkg::*;

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roots))
    else $error("stalled result changed");

  // no root or infinitely many: roots zero, no overflow
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (roots.root_count == CNT_NONE || roots.root_count == CNT_INF) |->
    roots.root_first == '0 && roots.root_second == '0 && !roots.overflow)
    else $error("absent roots not zero");

  // a single root is repeated
  a_single_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && roots.root_count == CNT_ONE |-> roots.root_first == roots.root_second)
    else $error("single root differs between outputs");

  // overflow only with actual roots
  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && roots.overflow |->
    roots.root_count == CNT_ONE || roots.root_count == CNT_TWO)
    else $error("overflow without roots");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .roots     (roots)
);

`default_nettype wire

// ===== tb/tb_quadratic_root_solver_top.sv =====
// Testbench for the quadratic root solver: random and directed coefficient requests,
// an in-file predictor of the roots and a scoreboard class. Depends on qrs_pkg and the top.
`timescale 1ns / 1ps

module tb_quadratic_root_solver_top;
  import qrs_pkg::*;

  localparam int FB = 16;
  localparam int LAT = 2 * 32 + FB + 8;
  localparam longint LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coef_t coef = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  roots_t roots;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  int errors = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic [TOL_W-1:0] tol_cur = TOL_RESET;

  quadratic_root_solver_top #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .coef(coef),
    .out_valid(out_valid), .out_ready(out_ready), .roots(roots),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mismatch report: one line, counted
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // one quotient num*2^FB/den, truncated, snapped and saturated
  function automatic logic [31:0] root_quot(input logic [127:0] num_m, input bit num_neg,
                                            input logic [127:0] den_m, input bit den_neg,
                                            input logic [127:0] thr, ref bit ovf);
    logic [127:0] q, lim;
    bit neg;
    neg = num_neg != den_neg;
    q = (num_m << FB) / den_m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q < thr) return 32'd0;
    if (q > lim) begin
      q = lim;
      ovf = 1'b1;
    end
    return neg ? (~q[31:0] + 32'd1) : q[31:0];
  endfunction

  function automatic logic [127:0] mag(input logic [31:0] v);
    return v[31] ? {96'd0, (~v + 32'd1)} : {96'd0, v};
  endfunction

  // floor square root; trial roots stay below 2^64 so the square fits
  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // signed add on sign/magnitude
  function automatic void sm_add(input bit xn, input logic [127:0] xm, input bit yn,
                                 input logic [127:0] ym, output bit rn,
                                 output logic [127:0] rm);
    if (xn == yn) begin
      rn = xn; rm = xm + ym;
    end else if (xm >= ym) begin
      rn = xn; rm = xm - ym;
    end else begin
      rn = yn; rm = ym - xm;
    end
  endfunction

  function automatic roots_t solve_roots(input coef_t cf, input logic [TOL_W-1:0] tol);
    roots_t r;
    logic [127:0] am, bm, cm, thr, thr2, bb, ac4, dm, den, sm, nm;
    bit an, bn, cn, dn, nn, ovf;
    r = '0;
    ovf = 1'b0;
    am = mag(cf.coef_quad); an = cf.coef_quad[31];
    bm = mag(cf.coef_lin); bn = cf.coef_lin[31];
    cm = mag(cf.coef_const); cn = cf.coef_const[31];
    thr = (tol == 0) ? 128'd1 : {112'd0, tol};
    thr2 = thr << FB;
    if (am < thr) begin
      if (bm < thr) begin
        r.root_count = (cm < thr) ? CNT_INF : CNT_NONE;
      end else begin
        r.root_count = CNT_ONE;
        r.root_first = root_quot(cm, !cn, bm, bn, thr, ovf);
        r.root_second = r.root_first;
      end
    end else begin
      bb = bm * bm;
      ac4 = (am * cm) << 2;
      sm_add(1'b0, bb, !(an != cn), ac4, dn, dm);
      den = am << 1;
      if (dm < thr2) begin
        r.root_count = CNT_ONE;
        r.root_first = root_quot(bm, !bn, den, an, thr, ovf);
        r.root_second = r.root_first;
      end else if (!dn) begin
        sm = isqrt(dm);
        r.root_count = CNT_TWO;
        sm_add(!bn, bm, 1'b0, sm, nn, nm);
        r.root_first = root_quot(nm, nn, den, an, thr, ovf);
        sm_add(!bn, bm, 1'b1, sm, nn, nm);
        r.root_second = root_quot(nm, nn, den, an, thr, ovf);
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  class roots_board;
    roots_t pending[$];
    function void note_request(roots_t want);
      pending.push_back(want);
    endfunction
    task check_roots(roots_t got);
      roots_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.root_count !== want.root_count)
        report_mismatch("root_count", 64'(got.root_count), 64'(want.root_count));
      if (got.root_first !== want.root_first)
        report_mismatch("root_first", 64'(got.root_first), 64'(want.root_first));
      if (got.root_second !== want.root_second)
        report_mismatch("root_second", 64'(got.root_second), 64'(want.root_second));
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
    endtask
  endclass

  roots_board board = new();

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_quadratic_root_solver_top: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, checks accepted results
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_roots(roots);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // valid drops only while idling or draining, so back-to-back requests stay high
  task automatic send_request(input coef_t cf);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coef <= cf;
    board.note_request(solve_roots(cf, tol_cur));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_cur = v;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(65535) - 32768;
      2: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      3: return $urandom_range(8) << 16 ^ ($urandom_range(1) ? 32'hffffffff : 32'd0);
      4: return $urandom_range(3) - 1;
      default: return {{4{$urandom_range(1) == 1}}, 28'($urandom)};
    endcase
  endfunction

  // well-formed equations: roots r1, r2 chosen, a*(x-r1)(x-r2)
  function automatic coef_t build_eq();
    coef_t cf;
    int ka, k1, k2;
    ka = $urandom_range(16) - 8;
    if (ka == 0) ka = 1;
    k1 = $urandom_range(40) - 20;
    k2 = ($urandom_range(3) == 0) ? k1 : $urandom_range(40) - 20;
    cf.coef_quad = ka <<< 16;
    cf.coef_lin = (-ka * (k1 + k2)) <<< 16;
    cf.coef_const = (ka * k1 * k2) <<< 16;
    if ($urandom_range(1)) cf.coef_const = cf.coef_const + ($urandom_range(4095) - 2048);
    return cf;
  endfunction

  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;

  initial begin
    coef_t cf;
    logic [31:0] dir [0:6];
    int n;
    dir = '{32'd0, 32'd1, 32'hffffffff, MAXV, MINV, 32'h00010000, 32'hffff0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: linear cases, infinite, none, double, two roots, saturating, extremes
    send_request('{32'd0, 32'd0, 32'd0});
    send_request('{32'd0, 32'd0, 32'h00010000});
    send_request('{32'd0, 32'h00020000, 32'h00010000});
    send_request('{32'd0, 32'd1, MAXV});
    send_request('{32'h00010000, 32'hfffe0000, 32'h00010000});
    send_request('{32'h00010000, 32'd0, 32'h00010000});
    send_request('{32'h00010000, 32'd0, 32'hfffc0000});
    send_request('{32'd1, MAXV, MINV});
    send_request('{MINV, MINV, MINV});
    send_request('{MAXV, MAXV, MAXV});
    send_request('{MAXV, MINV, MAXV});
    send_request('{32'd1, 32'd0, MINV});
    for (int i = 0; i < 7; i++) send_request('{dir[i], dir[(i + 3) % 7], dir[(i + 5) % 7]});
    drain_wait();

    // phases over tolerance settings and idling and stalling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_tolerance(16'd0);
        1: write_tolerance(16'hffff);
        2: write_tolerance(16'd1);
        3: write_tolerance(16'($urandom_range(65535)));
        4: write_tolerance(16'd64);
        5: write_tolerance(16'd0);
        6: write_tolerance(16'h8000);
        default: write_tolerance(16'd1);
      endcase
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 58; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 58; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      n = 190;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 65) cf = build_eq();
        else begin
          cf.coef_quad = rand_coef();
          cf.coef_lin = rand_coef();
          cf.coef_const = rand_coef();
        end
        send_request(cf);
      end
      drain_wait();
    end

    if (errors == 0) begin
      $display("tb_quadratic_root_solver_top: PASS");
    end else begin
      $display("tb_quadratic_root_solver_top: FAIL");
    end
    $finish;
  end

endmodule
